[rtl/mlfq_pkg.sv]
// types and constants shared by the feedback queue scheduler
package mlfq_pkg;

   localparam int LEVEL_COUNT = 3;
   localparam int ID_W        = 16;
   localparam int LEVEL_W     = 2;
   localparam int QUANT_W     = 22;
   localparam int BASE_W      = 20;
   localparam int VALUE_W     = 24;
   localparam int STATUS_W    = 4;
   localparam int OPCODE_W    = 2;

   localparam logic [BASE_W-1:0] QUANTUM_BASE_RESET = 20'd10000;

   localparam logic [OPCODE_W-1:0] OP_ADMIT    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REPORT   = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP    = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADMITTED     = 4'd0,
      ST_ADMIT_FULL   = 4'd1,
      ST_DISPATCHED   = 4'd2,
      ST_NONE_READY   = 4'd3,
      ST_REQUEUED     = 4'd4,
      ST_TERMINATED   = 4'd5,
      ST_BLOCKED      = 4'd6,
      ST_NO_DISPATCH  = 4'd7,
      ST_BUSY         = 4'd8,
      ST_REQUEUE_FULL = 4'd9
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic [ID_W-1:0]           process_id;
      logic signed [VALUE_W-1:0] report_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_process_id;
      logic [LEVEL_W-1:0]  out_level;
      logic [QUANT_W-1:0]  out_quantum;
   } rsp_type;

   // decided result waiting for the ring read data
   typedef struct packed {
      status_type         status;
      logic               use_rdata;
      logic [ID_W-1:0]    process_id;
      logic [LEVEL_W-1:0] level;
      logic [QUANT_W-1:0] quantum;
   } stage_type;

endpackage

[rtl/mlfq_three_level_scheduler.sv]
// top level of the three-level feedback queue scheduler
//
//   channel   handshake                 payload
//   req       req_valid / req_stall     req_payload (req_type)
//   rsp       rsp_valid / rsp_stall     rsp_payload (rsp_type)
//   csr       csr_write_enable          csr_write_data (quantum base)
//
// one request per cycle while the result side is not stalled; each result passes
// through the input register, the ring read register and the result register
// the ring read port and pointer update set the decision step
// synchronous reset empties every ring and clears the in-flight slot
// a stalled result freezes all three stages and stalls the request side
module mlfq_three_level_scheduler import mlfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_write_enable,
   input  logic [BASE_W-1:0] csr_write_data
);

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int MEM_DEPTH = LEVEL_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic              advance;
   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic [BASE_W-1:0] quantum_base_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [ID_W-1:0]   mem_wdata, mem_rdata;
   logic              s2_valid;
   stage_type         s2_stage;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_base_ff <= QUANTUM_BASE_RESET;
      end else if (csr_write_enable) begin
         quantum_base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         rsp_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff <= req_payload;
         rsp_ff    <= rsp_in;
      end
   end

   mlfq_queue_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .s1_valid     (s1_valid_ff),
      .s1_req       (s1_req_ff),
      .quantum_base (quantum_base_ff),
      .mem_rdata    (mem_rdata),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .s2_valid     (s2_valid),
      .s2_stage     (s2_stage)
   );

   mlfq_ring_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (mem_waddr),
      .write_data   (mem_wdata),
      .read_enable  (mem_re),
      .read_addr    (mem_raddr),
      .read_data    (mem_rdata)
   );

   always_comb begin
      rsp_in.status         = s2_stage.status;
      rsp_in.out_process_id = s2_stage.use_rdata ? mem_rdata : s2_stage.process_id;
      rsp_in.out_level      = s2_stage.level;
      rsp_in.out_quantum    = s2_stage.quantum;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a push and a pop never touch the same ring slot in one cycle
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("ring read and write collide");

   // results that carry no process report id and level zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == ST_NONE_READY
                     || rsp_payload.status == ST_NO_DISPATCH))
      |-> (rsp_payload.out_process_id == '0 && rsp_payload.out_level == LEVEL_TOP))
      else $error("empty result carries an id");

   // only a dispatch grants a quantum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_DISPATCHED) |-> (rsp_payload.out_quantum == '0))
      else $error("quantum on a result other than dispatch");

   // nothing comes out right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

[rtl/mlfq_ring_mem.sv]
// storage for the ready rings: one write port, one registered read port
module mlfq_ring_mem import mlfq_pkg::*; #(
   parameter int DEPTH  = 96,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [ID_W-1:0]   write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [ID_W-1:0]   read_data
);

   logic [ID_W-1:0] mem_ff [DEPTH];
   logic [ID_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

[rtl/mlfq_queue_ctrl.sv]
// ring pointers, in-flight slot and per-request decision
module mlfq_queue_ctrl import mlfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32,
   parameter int PTR_W       = 5,
   parameter int ADDR_W      = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              s1_valid,
   input  req_type           s1_req,
   input  logic [BASE_W-1:0] quantum_base,
   input  logic [ID_W-1:0]   mem_rdata,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [ID_W-1:0]   mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   output logic              s2_valid,
   output stage_type         s2_stage
);

   localparam logic [ADDR_W-1:0] L1_BASE  = ADDR_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] L2_BASE  = ADDR_W'(2 * QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [PTR_W-1:0]   head_ff [LEVEL_COUNT];
   logic [PTR_W-1:0]   head_in [LEVEL_COUNT];
   logic [PTR_W-1:0]   tail_ff [LEVEL_COUNT];
   logic [PTR_W-1:0]   tail_in [LEVEL_COUNT];
   logic [PTR_W-1:0]   head_next [LEVEL_COUNT];
   logic [PTR_W-1:0]   tail_next [LEVEL_COUNT];
   logic               ring_empty [LEVEL_COUNT];
   logic               ring_full [LEVEL_COUNT];
   logic [ADDR_W-1:0]  level_base [LEVEL_COUNT];

   logic               inflight_valid_ff, inflight_valid_in;
   logic [ID_W-1:0]    inflight_id_ff, inflight_id_in;
   logic [LEVEL_W-1:0] inflight_level_ff, inflight_level_in;
   logic [QUANT_W-1:0] inflight_quantum_ff, inflight_quantum_in;

   logic               s2_valid_ff, s2_valid_in;
   stage_type          s2_stage_ff, s2_stage_in;

   logic [ID_W-1:0]    eff_id;
   logic               found;
   logic [LEVEL_W-1:0] pick_lv;
   logic [LEVEL_W-1:0] tgt_lv;
   logic [QUANT_W-1:0] grant_q;

   assign level_base[0] = '0;
   assign level_base[1] = L1_BASE;
   assign level_base[2] = L2_BASE;

   always_comb begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         head_next[l]  = (head_ff[l] == PTR_LAST) ? '0 : head_ff[l] + 1'b1;
         tail_next[l]  = (tail_ff[l] == PTR_LAST) ? '0 : tail_ff[l] + 1'b1;
         ring_empty[l] = (head_ff[l] == tail_ff[l]);
         ring_full[l]  = (tail_next[l] == head_ff[l]);
      end
   end

   // in-flight id, taking the ring read that is still on its way
   assign eff_id = (s2_valid_ff && s2_stage_ff.use_rdata) ? mem_rdata : inflight_id_ff;

   always_comb begin
      found   = 1'b0;
      pick_lv = LEVEL_TOP;
      for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
         if (!ring_empty[l]) begin
            found   = 1'b1;
            pick_lv = LEVEL_W'(l);
         end
      end
      grant_q = QUANT_W'(quantum_base) << pick_lv;
      tgt_lv  = inflight_level_ff;
      if (({1'b0, inflight_quantum_ff} <= s1_req.report_value[VALUE_W-2:0])
          && (inflight_level_ff != LEVEL_BOTTOM)) begin
         tgt_lv = inflight_level_ff + 1'b1;
      end
   end

   always_comb begin
      head_in             = head_ff;
      tail_in             = tail_ff;
      inflight_valid_in   = inflight_valid_ff;
      inflight_id_in      = eff_id;
      inflight_level_in   = inflight_level_ff;
      inflight_quantum_in = inflight_quantum_ff;
      mem_we              = 1'b0;
      mem_waddr           = level_base[0] + ADDR_W'(tail_ff[0]);
      mem_wdata           = s1_req.process_id;
      mem_re              = 1'b0;
      mem_raddr           = level_base[pick_lv] + ADDR_W'(head_ff[pick_lv]);
      s2_valid_in         = 1'b0;
      s2_stage_in         = '{status: ST_NONE_READY, use_rdata: 1'b0, process_id: '0,
                              level: LEVEL_TOP, quantum: '0};
      if (s1_valid) begin
         case (s1_req.opcode)
            OP_ADMIT: begin
               s2_valid_in            = 1'b1;
               s2_stage_in.process_id = s1_req.process_id;
               if (ring_full[0]) begin
                  s2_stage_in.status = ST_ADMIT_FULL;
               end else begin
                  s2_stage_in.status = ST_ADMITTED;
                  mem_we             = advance;
                  tail_in[0]         = tail_next[0];
               end
            end
            OP_DISPATCH: begin
               s2_valid_in = 1'b1;
               if (inflight_valid_ff) begin
                  s2_stage_in.status     = ST_BUSY;
                  s2_stage_in.process_id = eff_id;
                  s2_stage_in.level      = inflight_level_ff;
               end else if (found) begin
                  s2_stage_in.status    = ST_DISPATCHED;
                  s2_stage_in.use_rdata = 1'b1;
                  s2_stage_in.level     = pick_lv;
                  s2_stage_in.quantum   = grant_q;
                  mem_re                = advance;
                  head_in[pick_lv]      = head_next[pick_lv];
                  inflight_valid_in     = 1'b1;
                  inflight_level_in     = pick_lv;
                  inflight_quantum_in   = grant_q;
               end
            end
            OP_REPORT: begin
               s2_valid_in = 1'b1;
               if (!inflight_valid_ff) begin
                  s2_stage_in.status = ST_NO_DISPATCH;
               end else begin
                  inflight_valid_in      = 1'b0;
                  s2_stage_in.process_id = eff_id;
                  s2_stage_in.level      = inflight_level_ff;
                  if (s1_req.report_value[VALUE_W-1]) begin
                     s2_stage_in.status = ST_TERMINATED;
                  end else if (s1_req.report_value == '0) begin
                     s2_stage_in.status = ST_BLOCKED;
                  end else begin
                     s2_stage_in.level = tgt_lv;
                     if (ring_full[tgt_lv]) begin
                        s2_stage_in.status = ST_REQUEUE_FULL;
                     end else begin
                        s2_stage_in.status = ST_REQUEUED;
                        mem_we             = advance;
                        mem_waddr          = level_base[tgt_lv] + ADDR_W'(tail_ff[tgt_lv]);
                        mem_wdata          = eff_id;
                        tail_in[tgt_lv]    = tail_next[tgt_lv];
                     end
                  end
               end
            end
            default: begin
               s2_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVEL_COUNT; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
         end
         inflight_valid_ff   <= 1'b0;
         inflight_id_ff      <= '0;
         inflight_level_ff   <= '0;
         inflight_quantum_ff <= '0;
         s2_valid_ff         <= 1'b0;
      end else if (advance) begin
         head_ff             <= head_in;
         tail_ff             <= tail_in;
         inflight_valid_ff   <= inflight_valid_in;
         inflight_id_ff      <= inflight_id_in;
         inflight_level_ff   <= inflight_level_in;
         inflight_quantum_ff <= inflight_quantum_in;
         s2_valid_ff         <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_stage_ff <= s2_stage_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_stage = s2_stage_ff;

endmodule

[tb/mlfq_scheduler_checker.sv]
// result checker for the three-level feedback queue scheduler
`timescale 1ns / 1ps
module mlfq_scheduler_checker import mlfq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_payload,
   input  logic              csr_write_enable,
   input  logic [BASE_W-1:0] csr_write_data,
   output int                mismatch_count,
   output int                outstanding
);

   logic [ID_W-1:0]    ready_ring [LEVEL_COUNT][QUEUE_DEPTH];
   int unsigned        ring_head [LEVEL_COUNT];
   int unsigned        ring_tail [LEVEL_COUNT];
   logic               run_valid;
   logic [ID_W-1:0]    run_id;
   logic [LEVEL_W-1:0] run_level;
   logic [QUANT_W-1:0] run_quantum;
   logic [BASE_W-1:0]  quantum_base;
   rsp_type            expected_results [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic int unsigned ring_advance(input int unsigned ptr);
      return (ptr + 1 == QUEUE_DEPTH) ? 0 : ptr + 1;
   endfunction

   function automatic bit ring_push(input int lv, input logic [ID_W-1:0] id);
      int unsigned next_tail;
      next_tail = ring_advance(ring_tail[lv]);
      if (next_tail == ring_head[lv]) return 1'b0;
      ready_ring[lv][ring_tail[lv]] = id;
      ring_tail[lv] = next_tail;
      return 1'b1;
   endfunction

   // updates the scheduler state and gives the result of one request
   function automatic bit schedule_outcome(input req_type item, output rsp_type res);
      int                 used;
      logic [LEVEL_W-1:0] target;
      res = '0;
      case (item.opcode)
         OP_ADMIT: begin
            res.status         = ring_push(0, item.process_id) ? ST_ADMITTED : ST_ADMIT_FULL;
            res.out_process_id = item.process_id;
         end
         OP_DISPATCH: begin
            if (run_valid) begin
               res.status         = ST_BUSY;
               res.out_process_id = run_id;
               res.out_level      = run_level;
            end else begin
               res.status = ST_NONE_READY;
               for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
                  if (!run_valid && ring_head[lv] != ring_tail[lv]) begin
                     run_id        = ready_ring[lv][ring_head[lv]];
                     ring_head[lv] = ring_advance(ring_head[lv]);
                     run_valid     = 1'b1;
                     run_level     = LEVEL_W'(lv);
                     run_quantum   = QUANT_W'(quantum_base) << lv;
                     res.status         = ST_DISPATCHED;
                     res.out_process_id = run_id;
                     res.out_level      = run_level;
                     res.out_quantum    = run_quantum;
                  end
               end
            end
         end
         OP_REPORT: begin
            if (!run_valid) begin
               res.status = ST_NO_DISPATCH;
            end else begin
               used               = int'(item.report_value);
               res.out_process_id = run_id;
               res.out_level      = run_level;
               if (used < 0) begin
                  res.status = ST_TERMINATED;
               end else if (used == 0) begin
                  res.status = ST_BLOCKED;
               end else begin
                  target = run_level;
                  // full quantum used drops one level
                  if (used >= int'(run_quantum) && run_level != LEVEL_BOTTOM) begin
                     target = run_level + 1'b1;
                  end
                  res.status    = ring_push(target, run_id) ? ST_REQUEUED : ST_REQUEUE_FULL;
                  res.out_level = target;
               end
               run_valid = 1'b0;
            end
         end
         default: begin
            return 1'b0;
         end
      endcase
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 200) begin
         $display("%0t mismatch in %s: got %0d want %0d", $time, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
            ring_head[lv] = 0;
            ring_tail[lv] = 0;
         end
         run_valid    = 1'b0;
         run_id       = '0;
         run_level    = '0;
         run_quantum  = '0;
         quantum_base = QUANTUM_BASE_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_results.size() == 0) begin
               report_mismatch("result with none expected, status", got.status, -1);
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.out_process_id != want.out_process_id)
                  report_mismatch("process id", got.out_process_id, want.out_process_id);
               if (got.out_level != want.out_level)
                  report_mismatch("level", got.out_level, want.out_level);
               if (got.out_quantum != want.out_quantum)
                  report_mismatch("quantum", got.out_quantum, want.out_quantum);
            end
         end
         if (req_valid && !req_stall) begin
            if (schedule_outcome(req_payload, want)) expected_results.push_back(want);
         end
         if (csr_write_enable) quantum_base = csr_write_data;
      end
      outstanding <= expected_results.size();
   end

endmodule

[tb/mlfq_three_level_scheduler_tb.sv]
// stimulus and verdict for the three-level feedback queue scheduler
`timescale 1ns / 1ps
module mlfq_three_level_scheduler_tb;
   import mlfq_pkg::*;

   localparam int QUEUE_DEPTH  = 32;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 380;
   localparam int SEGMENTS     = 6;
   localparam int HOLD_CYCLES  = 120;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_payload;
   logic              csr_write_enable;
   logic [BASE_W-1:0] csr_write_data;

   int                mismatch_count;
   int                outstanding;
   int                cycle_count = 0;
   int                issued_count = 0;
   bit                sender_quiet = 1'b0;
   bit                receiver_quiet = 1'b0;
   bit                hold_request = 1'b0;
   logic [BASE_W-1:0] quantum_setting = QUANTUM_BASE_RESET;

   mlfq_three_level_scheduler #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   mlfq_scheduler_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side stalls, with one long hold-off on demand
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !receiver_quiet && ($urandom_range(0, 99) < 28);
      end
   end

   function automatic req_type pack_request(input logic [OPCODE_W-1:0] op,
                                            input logic [ID_W-1:0] pid,
                                            input logic [VALUE_W-1:0] value);
      req_type item;
      item.opcode       = op;
      item.process_id   = pid;
      item.report_value = value;
      return item;
   endfunction

   // report times spread around the quantum of each level
   function automatic logic [VALUE_W-1:0] pick_report_value();
      int near;
      near = int'(quantum_setting) << $urandom_range(0, 2);
      near = near + int'($urandom_range(0, 2)) - 1;
      if (near < 1) near = 1;
      case ($urandom_range(0, 7))
         0: return VALUE_W'($urandom);
         1: return '0;
         2: return {1'b1, 23'($urandom)};
         3, 4, 5: return VALUE_W'(near);
         6: return VALUE_W'($urandom_range(1, 100));
         default: return {1'b0, 23'($urandom)};
      endcase
   endfunction

   task automatic send_request(input req_type item);
      while (!sender_quiet && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.opcode != OP_UNUSED) issued_count++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_quantum_base(input logic [BASE_W-1:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      quantum_setting  = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_dispatch();
      send_request(pack_request(OP_DISPATCH, ID_W'($urandom), VALUE_W'($urandom)));
   endtask

   task automatic send_report(input logic [VALUE_W-1:0] value);
      send_request(pack_request(OP_REPORT, ID_W'($urandom), value));
   endtask

   initial begin
      int seg;
      int shape;
      int run;
      int goal;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty scheduler, unused opcode, then the level walk at the reset quantum
      send_report(24'd5);
      send_dispatch();
      send_request(pack_request(OP_UNUSED, 16'hFFFF, 24'hFFFFFF));
      send_request(pack_request(OP_ADMIT, 16'h0000, 24'h000000));
      send_request(pack_request(OP_ADMIT, 16'hFFFF, 24'hFFFFFF));
      send_dispatch();
      send_dispatch();
      send_report(24'd9999);
      send_dispatch();
      send_report(24'd10000);
      send_dispatch();
      send_report(24'h800000);
      send_dispatch();
      send_report(24'h7FFFFF);
      send_dispatch();
      send_report(24'h7FFFFF);
      send_dispatch();
      send_report(24'd0);
      send_request(pack_request(OP_ADMIT, 16'h5A5A, 24'h5A5A5A));
      send_request(pack_request(OP_ADMIT, 16'hA5A5, 24'hA5A5A5));
      send_dispatch();
      send_report(24'hFFFFFF);

      // fill the top ring, then requeue onto it while full
      repeat (QUEUE_DEPTH) send_request(pack_request(OP_ADMIT, ID_W'($urandom), '0));
      send_dispatch();
      send_request(pack_request(OP_ADMIT, ID_W'($urandom), '0));
      send_report(24'd1);
      repeat (QUEUE_DEPTH) begin
         send_dispatch();
         send_report({1'b1, 23'($urandom)});
      end

      issued_count = 0;
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: write_quantum_base('0);
            1: write_quantum_base(20'd1);
            2: write_quantum_base(20'hFFFFF);
            default: write_quantum_base(BASE_W'($urandom_range(1, 20'hFFFFF)));
         endcase
         if (seg == 1) hold_request = 1'b1;
         if (seg == 3) begin
            sender_quiet   = 1'b1;
            receiver_quiet = 1'b1;
         end
         goal = (seg + 1) * RANDOM_ITEMS / SEGMENTS;
         while (issued_count < goal) begin
            shape = $urandom_range(0, 9);
            run   = $urandom_range(4, 16);
            repeat (run) begin
               if (shape < 5) begin
                  // mostly well-formed dispatch and report pairs
                  if ($urandom_range(0, 4) == 0) begin
                     send_request(pack_request(OP_ADMIT, ID_W'($urandom), VALUE_W'($urandom)));
                  end else begin
                     send_dispatch();
                     if ($urandom_range(0, 19) != 0) send_report(pick_report_value());
                     else send_request(pack_request(OPCODE_W'($urandom_range(0, 3)),
                                                    ID_W'($urandom), pick_report_value()));
                  end
               end else if (shape < 8) begin
                  send_request(pack_request(OPCODE_W'($urandom_range(0, 3)),
                                            ID_W'($urandom), pick_report_value()));
               end else begin
                  send_request(pack_request(OP_ADMIT, ID_W'($urandom), VALUE_W'($urandom)));
               end
            end
         end
         sender_quiet   = 1'b0;
         receiver_quiet = 1'b0;
      end

      wait_for_results();
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

[mlfq_three_level_scheduler.f]
rtl/mlfq_pkg.sv
rtl/mlfq_ring_mem.sv
rtl/mlfq_queue_ctrl.sv
rtl/mlfq_three_level_scheduler.sv
tb/mlfq_scheduler_checker.sv
tb/mlfq_three_level_scheduler_tb.sv
